// File: src/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg
// shared widths, command and status codes for the random sample set
// ----------------------------------------------------------------------------
package rss_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 64;

  typedef logic [1:0] cmd_t;
  typedef logic [2:0] status_t;

  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_REMOVE = 2'd1;
  localparam cmd_t CMD_PICK   = 2'd2;

  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_PRESENT = 3'd1;
  localparam status_t ST_ABSENT  = 3'd2;
  localparam status_t ST_FULL    = 3'd3;
  localparam status_t ST_EMPTY   = 3'd4;

endpackage

// File: src/rss_mem.sv
// ----------------------------------------------------------------------------
// rss_mem
// element store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module rss_mem #(
  parameter int DEPTH  = rss_pkg::CAPACITY_DEF,
  parameter int ADDR_W = $clog2(rss_pkg::CAPACITY_DEF)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [rss_pkg::DATA_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [rss_pkg::DATA_W-1:0]  rd_data
);
  import rss_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/rss_mod.sv
// ----------------------------------------------------------------------------
// rss_mod
// restoring remainder unit: one dividend bit per cycle
// ----------------------------------------------------------------------------
module rss_mod #(
  parameter int CNT_W = $clog2(rss_pkg::CAPACITY_DEF + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rss_pkg::DATA_W-1:0]  dividend,
  input  logic [CNT_W-1:0]            divisor,
  output logic                        done,
  output logic [CNT_W-1:0]            remainder
);
  import rss_pkg::*;

  localparam int STEP_W = $clog2(DATA_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DATA_W-1:0] dvd;
  logic [CNT_W-1:0]  dsr;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign trial = {remainder, dvd[DATA_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      dsr       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      dvd <= {dvd[DATA_W-2:0], 1'b0};
      // partial remainder always stays below the divisor
      if (fits) begin
        remainder <= CNT_W'(trial - {1'b0, dsr});
      end else begin
        remainder <= trial[CNT_W-1:0];
      end
    end
  end

endmodule

// File: src/random_sample_set_core.sv
// ----------------------------------------------------------------------------
// random_sample_set_core
// set of distinct 32-bit values with insert, remove and random pick
// ----------------------------------------------------------------------------
// Commands enter on the s_ group: s_tuser carries the command, s_tdata the
// value and the random word. One result word leaves on the m_ group per
// command: m_tdata is the picked value, m_tuser holds success and status.
// Live values sit packed in a single-port-read memory of CAPACITY entries.
// Insert and remove scan the live entries one per cycle through the memory
// read port; a remove that hits then reads the last entry and writes it over
// the matching slot. Random pick runs the remainder unit on the random word
// and the count, then one memory read at the remainder gives the picked
// value. One command is in flight at a time; s_tready rises the cycle after
// the result has been moved to the output register, so the next command can
// be taken while the previous result still waits for m_tready. If the
// receiver stalls, the following result waits in the core and s_tready stays
// low. Reset empties the set at once; memory contents need no clear.
// ----------------------------------------------------------------------------
module random_sample_set_core #(
  parameter int CAPACITY = rss_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [2*rss_pkg::DATA_W-1:0]  s_tdata,   // value, random_word
  input  rss_pkg::cmd_t                 s_tuser,   // cmd
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [rss_pkg::DATA_W-1:0]    m_tdata,   // picked_value
  output logic [3:0]                    m_tuser    // success, status
);
  import rss_pkg::*;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MOVE = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_PICK = 3'd4;
  localparam logic [2:0] S_RESP = 3'd5;

  logic [2:0]        state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  scan_idx;
  logic              chk_vld;
  logic [ADDR_W-1:0] chk_idx;
  logic [ADDR_W-1:0] slot;
  cmd_t              cmd_r;
  logic [DATA_W-1:0] key_r;
  logic              res_ok;
  logic [DATA_W-1:0] res_pick;
  status_t           res_status;

  logic              accept;
  logic              match;
  logic              scan_end;
  logic              full;
  logic [CNT_W-1:0]  last;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [DATA_W-1:0] rd_data;

  logic              mod_start;
  logic              mod_done;
  logic [CNT_W-1:0]  mod_rem;

  assign s_tready  = state == S_IDLE;
  assign accept    = s_tvalid && s_tready;
  assign match     = chk_vld && (rd_data == key_r);
  assign scan_end  = scan_idx == count;
  assign full      = count >= CNT_W'(CAPACITY);
  assign last      = count - 1'b1;
  assign mod_start = accept && (s_tuser == CMD_PICK) && (count != '0);

  // memory port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[ADDR_W-1:0];
    wr_data = key_r;
    rd_en   = 1'b0;
    rd_addr = scan_idx[ADDR_W-1:0];
    unique case (state)
      S_SCAN: begin
        if (match) begin
          if (cmd_r == CMD_REMOVE) begin
            rd_en   = 1'b1;
            rd_addr = last[ADDR_W-1:0];
          end
        end else if (!scan_end) begin
          rd_en = 1'b1;
        end else if (cmd_r == CMD_INSERT && !full) begin
          wr_en = 1'b1;
        end
      end
      S_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = slot;
        wr_data = rd_data;
      end
      S_DIV: begin
        rd_en   = mod_done;
        rd_addr = mod_rem[ADDR_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      chk_vld  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_RESP && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          chk_vld <= 1'b0;
          if (accept) begin
            if (s_tuser == CMD_INSERT || s_tuser == CMD_REMOVE) begin
              state <= S_SCAN;
            end else if (mod_start) begin
              state <= S_DIV;
            end else begin
              state <= S_RESP;
            end
          end
        end
        S_SCAN: begin
          chk_vld <= rd_en && !match;
          if (match) begin
            state <= (cmd_r == CMD_REMOVE) ? S_MOVE : S_RESP;
          end else if (scan_end) begin
            state <= S_RESP;
            if (cmd_r == CMD_INSERT && !full) begin
              count <= count + 1'b1;
            end
          end
        end
        S_MOVE: begin
          count <= last;
          state <= S_RESP;
        end
        S_DIV: begin
          if (mod_done) begin
            state <= S_PICK;
          end
        end
        S_PICK: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload and scan bookkeeping
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r      <= s_tuser;
      key_r      <= s_tdata[DATA_W-1:0];
      scan_idx   <= '0;
      res_ok     <= 1'b0;
      res_pick   <= '0;
      res_status <= (s_tuser == CMD_PICK && count == '0) ? ST_EMPTY : ST_OK;
    end
    if (state == S_SCAN) begin
      if (rd_en && !match) begin
        scan_idx <= scan_idx + 1'b1;
        chk_idx  <= scan_idx[ADDR_W-1:0];
      end
      if (match) begin
        slot <= chk_idx;
        if (cmd_r == CMD_REMOVE) begin
          res_ok <= 1'b1;
        end else begin
          res_status <= ST_PRESENT;
        end
      end else if (scan_end) begin
        if (cmd_r == CMD_REMOVE) begin
          res_status <= ST_ABSENT;
        end else if (full) begin
          res_status <= ST_FULL;
        end else begin
          res_ok <= 1'b1;
        end
      end
    end
    if (state == S_PICK) begin
      res_ok   <= 1'b1;
      res_pick <= rd_data;
    end
    if (state == S_RESP && (!m_tvalid || m_tready)) begin
      m_tdata <= res_pick;
      m_tuser <= {res_status, res_ok};
    end
  end

  rss_mem #(
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rss_mod #(
    .CNT_W (CNT_W)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (s_tdata[2*DATA_W-1:DATA_W]),
    .divisor   (count),
    .done      (mod_done),
    .remainder (mod_rem)
  );

endmodule
